>>> rtl/core/lfod_pkg.sv
// ----------------------------------------------------------------------------
// lfod_pkg: shared types and constants of the lidar frame obstacle detector
// Register indexes, opcodes, frame status codes and scan geometry.
// ----------------------------------------------------------------------------
package lfod_pkg;

  localparam int unsigned ScanDepth    = 360;
  localparam int unsigned FramePayload = 4;
  localparam int unsigned FrameBuffer  = 8;
  localparam int unsigned Sectors      = 181;
  localparam int unsigned ScanAw       = $clog2(ScanDepth);
  localparam int unsigned SecAw        = $clog2(Sectors);

  localparam logic [7:0]  ChOpen    = 8'h3C;
  localparam logic [7:0]  ChClose   = 8'h3E;
  localparam logic [15:0] BadHigh   = 16'd4000;
  localparam logic [15:0] RearFirst = 16'd180;
  localparam logic [15:0] RearLast  = 16'd360;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_NEAR    = 3'd0,
    REG_FAR     = 3'd1,
    REG_FLOOR   = 3'd2,
    REG_CEIL    = 3'd3,
    REG_UNSAFE  = 3'd4,
    REG_SILENCE = 3'd5
  } reg_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] sector_index;
  } in_item_t;

  typedef struct packed {
    logic        is_query_reply;
    logic [15:0] sample_angle;
    logic [15:0] sample_range;
    logic [1:0]  frame_status;
    logic        scan_closed;
    logic        safe;
    logic [8:0]  bad_range_count;
    logic        sector_blocked;
    logic        scanner_alive;
  } out_item_t;

endpackage

>>> rtl/core/lfod_stream_if.sv
// ----------------------------------------------------------------------------
// lfod_stream_if: valid/ready channel
// Carries one payload of type T per accepted request.
// ----------------------------------------------------------------------------
interface lfod_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/lfod_ram.sv
// ----------------------------------------------------------------------------
// lfod_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lfod_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> rtl/core/lidar_frame_obstacle_detector.sv
// ----------------------------------------------------------------------------
// lidar_frame_obstacle_detector: lidar deframer and rear obstacle detector
// Deframes serial samples, stores a scan and evaluates it at scan end.
// ----------------------------------------------------------------------------
// Requests: each request carries a serial byte, a time tick or a sector query,
// and gives at most one result. After reset the sector map RAM is cleared in
// a sweep over its 181 entries with in_if.ready low. A tick, an ignored opcode
// or a byte that does not close a frame is taken and gives no result. A query
// reads the sector map RAM in state S_QRY, and its result is registered from
// that state. A closing byte that does not end a scan passes through S_STORE
// and S_OUT before its result is registered. A closing byte that ends a scan
// first clears the sector map, then walks the N stored samples one per cycle
// through the sample RAM read port, then passes through S_STORE and S_OUT.
// The result sits in an output register; the next request is taken once that
// result has been delivered.
module lidar_frame_obstacle_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  lfod_stream_if.sink   in_if,
  lfod_stream_if.source out_if
);
  import lfod_pkg::*;

  typedef enum logic [7:0] {
    S_INIT  = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_QRY   = 8'b00000100,
    S_CLEAR = 8'b00001000,
    S_RD    = 8'b00010000,
    S_EVAL  = 8'b00100000,
    S_STORE = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_e;

  localparam logic [SecAw-1:0] SecLast = SecAw'(Sectors - 1);

  state_e state_q, state_d;

  // configuration
  logic [15:0] near_q, far_q;
  logic [3:0]  floor_q, ceil_q, unsafe_q;
  logic [23:0] silence_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= 16'd20; far_q <= 16'd1500; floor_q <= 4'd0;
      ceil_q <= 4'd3; unsafe_q <= 4'd2; silence_q <= 24'd1000000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NEAR:    near_q    <= cfg_data_i[15:0];
        REG_FAR:     far_q     <= cfg_data_i[15:0];
        REG_FLOOR:   floor_q   <= cfg_data_i[3:0];
        REG_CEIL:    ceil_q    <= cfg_data_i[3:0];
        REG_UNSAFE:  unsafe_q  <= cfg_data_i[3:0];
        REG_SILENCE: silence_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state
  logic        in_frame_q;
  logic [2:0]  byte_cnt_q;
  logic [7:0]  fb_q [FramePayload];
  logic [ScanAw:0] count_q;
  logic [15:0] last_ang_q, last_rng_q;
  logic [3:0]  filt_q;
  logic        safe_q;
  logic [8:0]  bad_q;
  logic [23:0] idle_q;
  logic        alive_q;
  // walk
  logic [ScanAw:0] walk_q;
  logic [SecAw-1:0] clr_q;
  logic            hit_q;
  logic [8:0]      wbad_q;
  logic [15:0]     ang_q, rng_q;
  logic [1:0]      stat_q;
  logic            closed_q;
  logic            qok_q;
  out_item_t       res_q, res_d;
  logic            res_v_q;
  logic            res_set;

  // sample RAM (angle and range packed)
  logic              ram_we;
  logic [ScanAw-1:0] ram_addr;
  logic [31:0]       ram_rdata;

  lfod_ram #(.Width(32), .Depth(ScanDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({ang_q, rng_q}),
    .rdata_o (ram_rdata)
  );

  // sector map RAM, one flag per rear sector
  logic             sec_we;
  logic [SecAw-1:0] sec_addr;
  logic             sec_wdata;
  logic             sec_rdata;

  lfod_ram #(.Width(1), .Depth(Sectors)) u_sec_ram (
    .clk_i   (clk_i),
    .we_i    (sec_we),
    .addr_i  (sec_addr),
    .wdata_i (sec_wdata),
    .rdata_o (sec_rdata)
  );

  in_item_t req;
  logic     acc;
  assign req = in_if.data;
  assign in_if.ready = (state_q == S_IDLE) && !res_v_q;
  assign acc = in_if.valid && in_if.ready;
  assign out_if.valid = res_v_q;
  assign out_if.data  = res_q;

  logic walk_live;
  assign walk_live = (walk_q <= count_q);
  assign ram_we = (state_q == S_STORE);
  always_comb begin
    if (state_q == S_STORE)
      ram_addr = (count_q < (ScanAw+1)'(ScanDepth)) ? count_q[ScanAw-1:0]
                                                    : ScanAw'(ScanDepth - 1);
    else
      ram_addr = walk_q[ScanAw-1:0];
  end

  // sample check on the registered read
  logic [15:0] wa, wr;
  logic        obst, bad;
  logic [SecAw-1:0] wsec;
  assign wa = ram_rdata[31:16];
  assign wr = ram_rdata[15:0];
  assign obst = (wa >= RearFirst) && (wa <= RearLast) && (wr < far_q) && (wr > near_q);
  assign bad = (wr <= 16'd1) || (wr >= BadHigh);
  assign wsec = SecAw'(wa - RearFirst);

  // sector RAM port: clear sweep, walk marks, query read
  always_comb begin
    sec_we    = 1'b0;
    sec_wdata = 1'b0;
    sec_addr  = clr_q;
    case (state_q)
      S_INIT, S_CLEAR: sec_we = 1'b1;
      S_EVAL: begin
        sec_addr  = wsec;
        sec_we    = walk_live && obst;
        sec_wdata = 1'b1;
      end
      default: sec_addr = req.sector_index;
    endcase
  end

  // filter step
  logic [4:0] fup, fdn;
  logic [3:0] fnext;
  assign fup = {1'b0, filt_q} + 5'd1;
  assign fdn = {1'b0, filt_q} - 5'd1;
  always_comb begin
    if (hit_q) fnext = (fup >= {1'b0, ceil_q}) ? ceil_q : fup[3:0];
    else fnext = (!fdn[4] && fdn[3:0] >= floor_q) ? fdn[3:0] : floor_q;
  end

  // frame assembly decode
  logic [15:0] fr_ang, fr_rng;
  assign fr_ang = (byte_cnt_q < 3'(FramePayload)) ? last_ang_q + 16'd1
                                                  : {fb_q[0], fb_q[1]};
  assign fr_rng = (byte_cnt_q < 3'(FramePayload)) ? last_rng_q : {fb_q[2], fb_q[3]};

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:  if (clr_q == SecLast) state_d = S_IDLE;
      S_IDLE: begin
        if (acc && req.opcode == OP_QUERY)
          state_d = S_QRY;
        else if (acc && req.opcode == OP_BYTE && in_frame_q && req.data_byte == ChClose)
          state_d = (fr_ang == 16'd0) ? S_CLEAR : S_STORE;
      end
      S_QRY:   state_d = S_IDLE;
      S_CLEAR: if (clr_q == SecLast) state_d = S_RD;
      S_RD:    state_d = S_EVAL;
      S_EVAL:  if (!walk_live) state_d = S_STORE;
      S_STORE: state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // result formatting
  assign res_set = (state_q == S_QRY) || (state_q == S_OUT);
  always_comb begin
    res_d = '0;
    res_d.safe            = safe_q;
    res_d.bad_range_count = bad_q;
    res_d.scanner_alive   = alive_q;
    if (state_q == S_QRY) begin
      res_d.is_query_reply = 1'b1;
      res_d.sector_blocked = qok_q && sec_rdata;
    end else begin
      res_d.sample_angle = ang_q;
      res_d.sample_range = rng_q;
      res_d.frame_status = stat_q;
      res_d.scan_closed  = closed_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && req.opcode == OP_BYTE && in_frame_q && req.data_byte != ChClose &&
        byte_cnt_q < 3'(FramePayload))
      fb_q[byte_cnt_q[1:0]] <= req.data_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; in_frame_q <= 1'b0; byte_cnt_q <= '0; count_q <= '0;
      last_ang_q <= '0; last_rng_q <= '0; filt_q <= '0;
      safe_q <= 1'b1; bad_q <= '0; idle_q <= '0; alive_q <= 1'b0;
      walk_q <= '0; clr_q <= '0; hit_q <= 1'b0; wbad_q <= '0;
      ang_q <= '0; rng_q <= '0; stat_q <= '0; closed_q <= 1'b0; qok_q <= 1'b0;
      res_q <= '0; res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_set) begin
        res_q   <= res_d;
        res_v_q <= 1'b1;
      end else if (out_if.ready) begin
        res_v_q <= 1'b0;
      end
      case (state_q)
        S_INIT: clr_q <= (clr_q == SecLast) ? '0 : clr_q + 1'b1;
        S_IDLE: if (acc) begin
          case (req.opcode)
            OP_TICK: begin
              if (idle_q != '1) idle_q <= idle_q + 24'd1;
              if (((idle_q != '1) ? idle_q + 24'd1 : idle_q) > silence_q)
                alive_q <= 1'b0;
            end
            OP_QUERY: qok_q <= (req.sector_index < 8'(Sectors));
            OP_BYTE: begin
              idle_q <= '0; alive_q <= 1'b1;
              if (!in_frame_q) begin
                if (req.data_byte == ChOpen) in_frame_q <= 1'b1;
              end else if (req.data_byte != ChClose) begin
                if (byte_cnt_q < 3'(FrameBuffer - 1)) byte_cnt_q <= byte_cnt_q + 3'd1;
              end else begin
                in_frame_q <= 1'b0; byte_cnt_q <= '0;
                ang_q <= fr_ang; rng_q <= fr_rng;
                stat_q <= (byte_cnt_q < 3'(FramePayload)) ? ST_SHORT :
                          (byte_cnt_q == 3'(FramePayload)) ? ST_OK : ST_LONG;
                walk_q <= '0; hit_q <= 1'b0; wbad_q <= '0;
                closed_q <= (fr_ang == 16'd0);
              end
            end
            default: ;
          endcase
        end
        // sector map clear sweep, one entry per cycle
        S_CLEAR: clr_q <= (clr_q == SecLast) ? '0 : clr_q + 1'b1;
        S_RD: walk_q <= walk_q + 1'b1;
        // read data for entry walk_q-1 is present here
        S_EVAL: begin
          if (walk_live) begin
            if (obst) hit_q <= 1'b1;
            if (bad && wbad_q != 9'h1FF) wbad_q <= wbad_q + 9'd1;
            walk_q <= walk_q + 1'b1;
          end else begin
            filt_q  <= fnext;
            safe_q  <= fnext < unsafe_q;
            bad_q   <= wbad_q;
            count_q <= '0;
          end
        end
        S_STORE: begin
          if (count_q < (ScanAw+1)'(ScanDepth)) count_q <= count_q + 1'b1;
          last_ang_q <= ang_q; last_rng_q <= rng_q;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> state_q == S_IDLE) else $error("ready outside idle");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && !out_if.ready |=> res_v_q) else $error("result dropped");
  a_fsm_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (ScanAw+1)'(ScanDepth)) else $error("sample count overflow");
`endif
endmodule
